### design/gcpa_pkg.sv
// Shared types, constants and the command packet length table for the
// GPU command port assembler. No dependencies.

package gcpa_pkg;

  // Access kind carried on the input tuser field
  typedef enum logic [1:0] {
    MODE_DATA_WR   = 2'd0,
    MODE_CTRL_WR   = 2'd1,
    MODE_DATA_RD   = 2'd2,
    MODE_STATUS_RD = 2'd3
  } mode_t;

  // Control port commands (top byte of the written word)
  localparam logic [7:0] CMD_RESET      = 8'h00;
  localparam logic [7:0] CMD_FLUSH      = 8'h01;
  localparam logic [7:0] CMD_IRQ_ACK    = 8'h02;
  localparam logic [7:0] CMD_DISP_EN    = 8'h03;
  localparam logic [7:0] CMD_DMA_DIR    = 8'h04;
  localparam logic [7:0] CMD_DISP_MODE  = 8'h08;
  localparam logic [7:0] CMD_TEX_DIS    = 8'h09;

  // Data port opcodes with a register effect
  localparam logic [7:0] OP_DRAW_MODE   = 8'hE1;
  localparam logic [7:0] OP_CLIP_START  = 8'hE3;
  localparam logic [7:0] OP_CLIP_END    = 8'hE4;
  localparam logic [7:0] OP_DRAW_OFFSET = 8'hE5;

  // DMA direction codes that let data writes through
  localparam logic [1:0] DIR_OFF       = 2'd0;
  localparam logic [1:0] DIR_CPU_TO_GPU = 2'd2;

  localparam logic [31:0] STATUS_RESET = 32'h1480_2000;

  // Status bit positions
  localparam int unsigned ST_TEX_DIS   = 15;
  localparam int unsigned ST_HRES2     = 16;
  localparam int unsigned ST_HRES1_LO  = 17;
  localparam int unsigned ST_VRES      = 19;
  localparam int unsigned ST_VMODE     = 20;
  localparam int unsigned ST_DEPTH     = 21;
  localparam int unsigned ST_INTERLACE = 22;
  localparam int unsigned ST_DISP_DIS  = 23;
  localparam int unsigned ST_IRQ       = 24;
  localparam int unsigned ST_CMD_RDY   = 26;
  localparam int unsigned ST_DMA_RDY   = 28;
  localparam int unsigned ST_DIR_LO    = 29;

  // Packet length in words for each opcode; zero means no packet
  function automatic logic [3:0] pkt_len(input logic [7:0] op);
    logic [3:0] len;
    len = 4'd0;
    unique casez (op)
      8'h01:        len = 4'd1;
      8'h02:        len = 4'd3;
      8'b0010_00??: len = 4'd4;
      8'b0010_01??: len = 4'd7;
      8'b0010_10??: len = 4'd5;
      8'b0010_11??: len = 4'd9;
      8'b0011_00??: len = 4'd6;
      8'b0011_01??: len = 4'd9;
      8'b0011_10??: len = 4'd8;
      8'b0011_11??: len = 4'd12;
      8'b0100_00??: len = 4'd3;
      8'b0100_10??: len = 4'd5;
      8'b0100_11??: len = 4'd6;
      8'b0101_00??: len = 4'd4;
      8'b0101_10??: len = 4'd7;
      8'b0101_11??: len = 4'd9;
      8'b0110_00??: len = 4'd3;
      8'b0110_01??: len = 4'd4;
      8'b0110_10??: len = 4'd2;
      8'b0111_00??: len = 4'd2;
      8'b0111_01??: len = 4'd3;
      8'b0111_10??: len = 4'd2;
      8'b0111_11??: len = 4'd3;
      8'h80:        len = 4'd4;
      8'hA0:        len = 4'd3;
      8'hC0:        len = 4'd3;
      8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5, 8'hE6: len = 4'd1;
      default:      len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

### design/gpu_command_port_assembler.sv
// GPU command port assembler: one bus access per transfer, result per access.
// Depends on gcpa_pkg (access kinds, command codes, packet length table).

// Each input transfer is one access to the command port: a data write, a
// control write, a data read or a status read (in_tuser). The block takes one
// transfer per cycle while the output register is empty or being taken; its
// result appears in the output register on the next cycle and waits there
// until taken, while a new transfer is taken in the same cycle the old result
// leaves. The transfer rate is set by the single registered update of the
// status, packet counter and drawing registers, which every access reads and
// writes. Results carry the read data, a packet-complete flag, the current
// opcode and the clip and offset registers as they stand after the access.

module gpu_command_port_assembler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // word[31:0], dma_ready[32], zero[39:33]
  input  logic [1:0]   in_tuser,   // mode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // read_data[31:0], packet_done[32],
                                   // packet_opcode[40:33], clip_left[50:41],
                                   // clip_top[60:51], clip_right[70:61],
                                   // clip_bottom[80:71], draw_offset_x[91:81],
                                   // draw_offset_y[102:92], zero[103]
);
  import gcpa_pkg::*;

  logic [31:0] status_r, status_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [23:0] param_r, param_nxt;
  logic [31:0] last_r, last_nxt;
  logic [9:0]  clip_r   [4];
  logic [9:0]  clip_nxt [4];
  logic [10:0] off_r    [2];
  logic [10:0] off_nxt  [2];

  logic         out_valid_r;
  logic [103:0] out_data_r;

  logic        in_xfer;
  mode_t       mode;
  logic [31:0] word;
  logic        dma_ready;
  logic [1:0]  dir;
  logic        accept;
  logic [7:0]  op_eff;
  logic [3:0]  len;
  logic [3:0]  cnt_inc;
  logic        done;
  logic [31:0] rd;
  logic [7:0]  cmd;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign mode       = mode_t'(in_tuser);
  assign word       = in_tdata[31:0];
  assign dma_ready  = in_tdata[32];
  assign dir        = status_r[ST_DIR_LO +: 2];
  assign cmd        = word[31:24];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Decode the access and work out the next register state
  always_comb begin
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    opcode_nxt = opcode_r;
    param_nxt  = param_r;
    last_nxt   = last_r;
    clip_nxt   = clip_r;
    off_nxt    = off_r;
    done       = 1'b0;
    rd         = 32'd0;
    accept     = (dir == DIR_OFF) || ((dir == DIR_CPU_TO_GPU) && dma_ready);
    op_eff     = (cnt_r == 4'd0) ? word[31:24] : opcode_r;
    len        = pkt_len(op_eff);
    cnt_inc    = cnt_r + 4'd1;

    unique case (mode)
      MODE_DATA_WR: begin
        // Gather the word into the current packet
        if (accept) begin
          last_nxt = word;
          if (cnt_r == 4'd0) begin
            opcode_nxt = word[31:24];
          end
          if (len != 4'd0) begin
            if (cnt_r == 4'd0) begin
              param_nxt = word[23:0];
            end
            if (cnt_inc == len) begin
              done    = 1'b1;
              cnt_nxt = 4'd0;
              // Apply the completed packet
              unique case (op_eff)
                OP_DRAW_MODE:   status_nxt[10:0] = param_nxt[10:0];
                OP_CLIP_START: begin
                  clip_nxt[0] = param_nxt[9:0];
                  clip_nxt[1] = param_nxt[19:10];
                end
                OP_CLIP_END: begin
                  clip_nxt[2] = param_nxt[9:0];
                  clip_nxt[3] = param_nxt[19:10];
                end
                OP_DRAW_OFFSET: begin
                  off_nxt[0] = param_nxt[10:0];
                  off_nxt[1] = param_nxt[21:11];
                end
                default: ;
              endcase
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
        end
        status_nxt[ST_CMD_RDY] = 1'b1;
        status_nxt[ST_DMA_RDY] = 1'b1;
      end
      MODE_CTRL_WR: begin
        unique case (cmd)
          CMD_RESET: begin
            cnt_nxt    = 4'd0;
            opcode_nxt = 8'd0;
            param_nxt  = 24'd0;
            status_nxt = STATUS_RESET;
          end
          CMD_FLUSH: begin
            cnt_nxt    = 4'd0;
            opcode_nxt = 8'd0;
            param_nxt  = 24'd0;
          end
          CMD_IRQ_ACK:  status_nxt[ST_IRQ] = 1'b0;
          CMD_DISP_EN:  status_nxt[ST_DISP_DIS] = word[0];
          CMD_DMA_DIR:  status_nxt[ST_DIR_LO +: 2] = word[1:0];
          CMD_DISP_MODE: begin
            status_nxt[ST_HRES2]          = word[6];
            status_nxt[ST_HRES1_LO +: 2]  = word[1:0];
            status_nxt[ST_VRES]           = word[2];
            status_nxt[ST_VMODE]          = word[3];
            status_nxt[ST_DEPTH]          = word[4];
            status_nxt[ST_INTERLACE]      = word[5];
          end
          CMD_TEX_DIS:  status_nxt[ST_TEX_DIS] = word[0];
          default: ;
        endcase
      end
      MODE_DATA_RD:   rd = (dir == DIR_OFF) ? last_r : 32'd0;
      MODE_STATUS_RD: rd = status_r;
      default: ;
    endcase
  end

  // Advance the port state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= STATUS_RESET;
      cnt_r    <= 4'd0;
      opcode_r <= 8'd0;
      param_r  <= 24'd0;
      last_r   <= 32'd0;
      clip_r   <= '{default: 10'd0};
      off_r    <= '{default: 11'd0};
    end else if (in_xfer) begin
      status_r <= status_nxt;
      cnt_r    <= cnt_nxt;
      opcode_r <= opcode_nxt;
      param_r  <= param_nxt;
      last_r   <= last_nxt;
      clip_r   <= clip_nxt;
      off_r    <= off_nxt;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {1'b0, off_nxt[1], off_nxt[0], clip_nxt[3], clip_nxt[2],
                     clip_nxt[1], clip_nxt[0], opcode_nxt, done, rd};
    end
  end

endmodule
